[rtl/tdc_pkg.sv]
// Package for the tridigital cipher engine: opcodes, status codes, sequencer states.
// No dependencies.
`default_nettype none
package tdc_pkg;
	localparam logic [3:0] OP_START = 4'd0;
	localparam logic [3:0] OP_COLKEY = 4'd1;
	localparam logic [3:0] OP_ALPHAKEY = 4'd2;
	localparam logic [3:0] OP_FIN_KEY = 4'd3;
	localparam logic [3:0] OP_ALPHA = 4'd4;
	localparam logic [3:0] OP_DIGIT = 4'd5;
	localparam logic [3:0] OP_FIN_DIR = 4'd6;
	localparam logic [3:0] OP_ENC = 4'd7;
	localparam logic [3:0] OP_QUERY = 4'd8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_NOGRID = 2'd2;
	localparam logic [1:0] ST_NOCAND = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RANK,
		S_DCHK,
		S_ACHK,
		S_FILL,
		S_COMMIT,
		S_QUERY,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

[rtl/tridigital_cipher_engine_core.sv]
// Top level of the tridigital cipher engine: sequencer, buffers and grid tables.
// Depends on tdc_pkg.
// Entry, encipher and unknown items: 1 result each (accept, then result held until transfer).
// Query: 2 or 3 results for a candidate digit, else 1 (table read, then result held until transfer).
// Keyword finish: rank, then fill, then commit steps; direct finish: digit check, alphabet
// check, then commit steps. Ranking goes through one compare unit.
// Reset clears counts, masks, error and grid-valid; tables are undefined until a build.
`default_nettype none
module tridigital_cipher_engine_core import tdc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [3:0] opcode,
	input wire logic [7:0] value,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [4:0] result_value,
	output logic last
);
	state_t state_q;
	logic [4:0] ckbuf_q [10];
	logic [4:0] abuf_q [26];
	logic [3:0] ckcnt_q;
	logic [4:0] acnt_q;
	logic [25:0] cmask_q, amask_q, used_q;
	logic err_q, gvalid_q;
	logic [3:0] dig_of_let_q [26];
	logic [4:0] let_of_col_q [27];
	logic [3:0] col_of_dig_q [10];
	logic [3:0] sep_q;
	logic [3:0] digits_q [10];
	logic [4:0] alpha_q [26];
	logic [3:0] i_q, j_q, rank_q;
	logic [4:0] k_q, n_q;
	logic [4:0] scan_q;
	logic [9:0] seen_q;
	logic [1:0] st_q;
	logic [4:0] val_q;
	logic [3:0] qcol_q;
	logic [1:0] qrow_q;
	logic fold_ok;
	logic [4:0] fold_l;
	logic [7:0] fb;
	logic cmp_lt;
	logic [3:0] col_k, row_k;
	logic [4:0] ltr_k;
	logic [1:0] idle_st;
	logic [4:0] idle_val;
	state_t idle_next;

	always_comb begin
		fb = value;
		if (value >= 8'h61 && value <= 8'h7a)
			fb = value - 8'd32;
		fold_ok = (fb >= 8'h41 && fb <= 8'h5a);
		fold_l = 5'(fb - 8'h41);
	end

	// shared compare unit for ranking
	assign cmp_lt = (ckbuf_q[j_q] < ckbuf_q[i_q]) ||
		((ckbuf_q[j_q] == ckbuf_q[i_q]) && (j_q < i_q));

	always_comb begin
		if (k_q < 5'd9) begin
			col_k = k_q[3:0]; row_k = 4'd0;
		end else if (k_q < 5'd18) begin
			col_k = 4'(k_q - 5'd9); row_k = 4'd1;
		end else begin
			col_k = 4'(k_q - 5'd18); row_k = 4'd2;
		end
		ltr_k = alpha_q[k_q];
	end

	// status, value and next state for an item accepted in idle
	always_comb begin
		idle_st = ST_OK;
		idle_val = '0;
		idle_next = S_OUT;
		case (opcode)
			OP_FIN_KEY: begin
				if (ckcnt_q != 4'd10) idle_st = ST_REJECT;
				else idle_next = S_RANK;
			end
			OP_FIN_DIR: begin
				if (err_q || acnt_q != 5'd26 || ckcnt_q != 4'd10) idle_st = ST_REJECT;
				else idle_next = S_DCHK;
			end
			OP_ENC: begin
				if (!gvalid_q) idle_st = ST_NOGRID;
				else if (value < 8'd26) idle_val = {1'b0, dig_of_let_q[value[4:0]]};
				else idle_val = {1'b0, sep_q};
			end
			OP_QUERY: begin
				if (!gvalid_q) idle_st = ST_NOGRID;
				else if (value > 8'd9 || value[3:0] == sep_q) idle_st = ST_NOCAND;
				else if (col_of_dig_q[value[3:0]] > 4'd8) idle_st = ST_NOCAND;
				else idle_next = S_QUERY;
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign status = st_q;
	assign result_value = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ckcnt_q <= '0; acnt_q <= '0; cmask_q <= '0; amask_q <= '0;
			err_q <= 1'b0; gvalid_q <= 1'b0; sep_q <= '0;
			out_valid <= 1'b0; last <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						st_q <= idle_st; val_q <= idle_val; last <= 1'b1;
						state_q <= idle_next;
						out_valid <= (idle_next == S_OUT);
						case (opcode)
							OP_START: begin
								ckcnt_q <= '0; acnt_q <= '0; cmask_q <= '0;
								amask_q <= '0; err_q <= 1'b0;
							end
							OP_COLKEY: begin
								if (fold_ok && ckcnt_q < 4'd10 && !cmask_q[fold_l]) begin
									cmask_q[fold_l] <= 1'b1;
									ckbuf_q[ckcnt_q] <= fold_l;
									ckcnt_q <= ckcnt_q + 4'd1;
								end
							end
							OP_ALPHAKEY: begin
								if (fold_ok && acnt_q < 5'd26 && !amask_q[fold_l]) begin
									amask_q[fold_l] <= 1'b1;
									abuf_q[acnt_q] <= fold_l;
									acnt_q <= acnt_q + 5'd1;
								end
							end
							OP_FIN_KEY: begin
								i_q <= '0; j_q <= '0; rank_q <= 4'd1;
							end
							OP_ALPHA: begin
								if (value > 8'd25 || acnt_q >= 5'd26 || amask_q[value[4:0]])
									err_q <= 1'b1;
								else begin
									amask_q[value[4:0]] <= 1'b1;
									abuf_q[acnt_q] <= value[4:0];
									acnt_q <= acnt_q + 5'd1;
								end
							end
							OP_DIGIT: begin
								if (value > 8'd9 || ckcnt_q >= 4'd10 || cmask_q[value[4:0]])
									err_q <= 1'b1;
								else begin
									cmask_q[value[4:0]] <= 1'b1;
									ckbuf_q[ckcnt_q] <= value[4:0];
									ckcnt_q <= ckcnt_q + 4'd1;
								end
							end
							OP_FIN_DIR: begin
								i_q <= '0; seen_q <= '0;
							end
							OP_QUERY: begin
								if (idle_next == S_QUERY) begin
									qcol_q <= col_of_dig_q[value[3:0]];
									qrow_q <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				S_RANK: begin
					if (j_q == 4'd9) begin
						digits_q[i_q] <= (4'(rank_q + 4'(cmp_lt)) == 4'd10) ? 4'd0 :
							4'(rank_q + 4'(cmp_lt));
						j_q <= '0; rank_q <= 4'd1;
						if (i_q == 4'd9) begin
							i_q <= '0; k_q <= '0; n_q <= '0; used_q <= '0;
							scan_q <= '0;
							state_q <= S_FILL;
						end else i_q <= i_q + 4'd1;
					end else begin
						rank_q <= rank_q + 4'(cmp_lt);
						j_q <= j_q + 4'd1;
					end
				end
				S_FILL: begin
					// k_q: alphabet buffer step; scan_q: letters 0..25; n_q: filled
					if (n_q == 5'd26) begin
						k_q <= '0; state_q <= S_COMMIT;
					end else if (k_q < acnt_q) begin
						if (!used_q[abuf_q[k_q]]) begin
							used_q[abuf_q[k_q]] <= 1'b1;
							alpha_q[n_q] <= abuf_q[k_q];
							n_q <= n_q + 5'd1;
						end
						k_q <= k_q + 5'd1;
					end else begin
						if (!used_q[scan_q]) begin
							used_q[scan_q] <= 1'b1;
							alpha_q[n_q] <= scan_q;
							n_q <= n_q + 5'd1;
						end
						scan_q <= scan_q + 5'd1;
					end
				end
				S_DCHK: begin
					if (ckbuf_q[i_q] > 5'd9 || seen_q[ckbuf_q[i_q][3:0]]) begin
						st_q <= ST_REJECT; out_valid <= 1'b1; state_q <= S_OUT;
					end else begin
						seen_q[ckbuf_q[i_q][3:0]] <= 1'b1;
						digits_q[i_q] <= ckbuf_q[i_q][3:0];
						if (i_q == 4'd9) begin
							k_q <= '0; used_q <= '0; state_q <= S_ACHK;
						end else i_q <= i_q + 4'd1;
					end
				end
				S_ACHK: begin
					if (abuf_q[k_q] > 5'd25 || used_q[abuf_q[k_q]]) begin
						st_q <= ST_REJECT; out_valid <= 1'b1; state_q <= S_OUT;
					end else begin
						used_q[abuf_q[k_q]] <= 1'b1;
						alpha_q[k_q] <= abuf_q[k_q];
						if (k_q == 5'd25) begin
							k_q <= '0; state_q <= S_COMMIT;
						end else k_q <= k_q + 5'd1;
					end
				end
				S_COMMIT: begin
					dig_of_let_q[ltr_k] <= digits_q[col_k];
					let_of_col_q[5'(col_k) * 5'd3 + 5'(row_k)] <= ltr_k;
					if (k_q < 5'd10) col_of_dig_q[digits_q[k_q[3:0]]] <= k_q[3:0];
					if (k_q == 5'd25) begin
						let_of_col_q[26] <= '0;
						sep_q <= digits_q[9];
						gvalid_q <= 1'b1;
						st_q <= ST_OK; val_q <= '0; last <= 1'b1;
						out_valid <= 1'b1; state_q <= S_OUT;
					end else k_q <= k_q + 5'd1;
				end
				S_QUERY: begin
					st_q <= ST_OK;
					val_q <= let_of_col_q[5'(qcol_q) * 5'd3 + 5'(qrow_q)];
					last <= (qrow_q == 2'd2) || (qcol_q == 4'd8 && qrow_q == 2'd1);
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (last) state_q <= S_IDLE;
						else begin
							qrow_q <= qrow_q + 2'd1;
							state_q <= S_QUERY;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[dv/tridigital_cipher_engine_core_tb.sv]
// Testbench for tridigital_cipher_engine_core: keyword and direct grid builds, encipher
// and candidate queries, checked against an in-bench grid model with a result queue.
// Depends on tdc_pkg and the core RTL.
`timescale 1ns / 100ps

module tridigital_cipher_engine_core_tb import tdc_pkg::*; ();

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] result_value;
		logic last;
	} cipher_result_t;

	class grid_scoreboard;
		int ckey[10];
		int ccount;
		bit [25:0] cseen;
		int abuf[26];
		int acount;
		bit [25:0] aused;
		bit lerr;
		int let_dig[26];
		int col_lets[27];
		int dig_col[10];
		int sep;
		bit gvalid;
		cipher_result_t pending_q[$];
		int errors;

		function new();
			ccount = 0; cseen = 0; acount = 0; aused = 0;
			lerr = 0; sep = 0; gvalid = 0; errors = 0;
		endfunction

		function int fold_letter(int b);
			if (b >= "a" && b <= "z") b -= 32;
			if (b >= "A" && b <= "Z") return b - "A";
			return -1;
		endfunction

		function void commit(int a[26], int d[10]);
			int c;
			int r;
			for (int k = 0; k < 10; k++) dig_col[d[k]] = k;
			sep = d[9];
			for (int k = 0; k < 26; k++) begin
				c = k % 9;
				r = k / 9;
				let_dig[a[k] % 26] = d[c];
				col_lets[c * 3 + r] = a[k] % 26;
			end
			col_lets[26] = 0;
			gvalid = 1;
		endfunction

		function logic [1:0] finish_keyword();
			int d[10];
			int a[26];
			int rank;
			int k;
			bit [25:0] used;
			if (ccount != 10) return ST_REJECT;
			for (int i = 0; i < 10; i++) begin
				rank = 1;
				for (int j = 0; j < 10; j++)
					if (ckey[j] < ckey[i] || (ckey[j] == ckey[i] && j < i)) rank++;
				d[i] = rank % 10;
			end
			k = 0;
			used = 0;
			for (int i = 0; i < acount && i < 26; i++)
				if (!used[abuf[i] % 26]) begin
					used[abuf[i] % 26] = 1;
					a[k++] = abuf[i] % 26;
				end
			for (int i = 0; i < 26 && k < 26; i++)
				if (!used[i]) a[k++] = i;
			commit(a, d);
			return ST_OK;
		endfunction

		function logic [1:0] finish_direct();
			bit [31:0] seen;
			if (lerr || acount != 26 || ccount != 10) return ST_REJECT;
			seen = 0;
			for (int i = 0; i < 10; i++) begin
				if (ckey[i] > 9 || seen[ckey[i]]) return ST_REJECT;
				seen[ckey[i]] = 1;
			end
			seen = 0;
			for (int i = 0; i < 26; i++) begin
				if (abuf[i] > 25 || seen[abuf[i]]) return ST_REJECT;
				seen[abuf[i]] = 1;
			end
			commit(abuf, ckey);
			return ST_OK;
		endfunction

		function void push(logic [1:0] st, int v, bit l);
			cipher_result_t e;
			e.status = st;
			e.result_value = v[4:0];
			e.last = l;
			pending_q.push_back(e);
		endfunction

		function void note_input(logic [3:0] op, logic [7:0] val);
			int lt;
			int v;
			int col;
			int n;
			v = val;
			case (op)
				OP_START: begin
					ccount = 0; cseen = 0; acount = 0; aused = 0; lerr = 0;
					push(ST_OK, 0, 1);
				end
				OP_COLKEY: begin
					lt = fold_letter(v);
					if (lt >= 0 && ccount < 10 && !cseen[lt]) begin
						cseen[lt] = 1;
						ckey[ccount++] = lt;
					end
					push(ST_OK, 0, 1);
				end
				OP_ALPHAKEY: begin
					lt = fold_letter(v);
					if (lt >= 0 && acount < 26 && !aused[lt]) begin
						aused[lt] = 1;
						abuf[acount++] = lt;
					end
					push(ST_OK, 0, 1);
				end
				OP_FIN_KEY: push(finish_keyword(), 0, 1);
				OP_ALPHA: begin
					if (v > 25 || acount >= 26 || aused[v]) lerr = 1;
					else begin
						aused[v] = 1;
						abuf[acount++] = v;
					end
					push(ST_OK, 0, 1);
				end
				OP_DIGIT: begin
					if (v > 9 || ccount >= 10 || cseen[v]) lerr = 1;
					else begin
						cseen[v] = 1;
						ckey[ccount++] = v;
					end
					push(ST_OK, 0, 1);
				end
				OP_FIN_DIR: push(finish_direct(), 0, 1);
				OP_ENC: begin
					if (!gvalid) push(ST_NOGRID, 0, 1);
					else push(ST_OK, (v < 26) ? let_dig[v] : sep, 1);
				end
				OP_QUERY: begin
					if (!gvalid) push(ST_NOGRID, 0, 1);
					else if (v > 9 || v == sep || dig_col[v] > 8) push(ST_NOCAND, 0, 1);
					else begin
						col = dig_col[v];
						n = (col == 8) ? 2 : 3;
						for (int i = 0; i < n; i++)
							push(ST_OK, col_lets[col * 3 + i], i == n - 1);
					end
				end
				default: push(ST_OK, 0, 1);
			endcase
		endfunction

		function void check_result(logic [1:0] st, logic [4:0] rv, logic l);
			cipher_result_t e;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status=%0d value=%0d last=%0d",
					$time, st, rv, l);
				return;
			end
			e = pending_q.pop_front();
			if (e.status !== st || e.result_value !== rv || e.last !== l) begin
				errors++;
				$display("%0t: mismatch expected status=%0d value=%0d last=%0d, got %0d %0d %0d",
					$time, e.status, e.result_value, e.last, st, rv, l);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [3:0] opcode;
	logic [7:0] value;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic [4:0] result_value;
	logic last;

	grid_scoreboard sb;
	bit quiet;
	bit hold_go;
	int hold_left;
	int sent;

	tridigital_cipher_engine_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.result_value(result_value),
		.last(last)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tridigital_cipher_engine_core_tb: errors");
		$finish;
	end

	// result side: random stall, with a long hold-off on request
	initial begin
		out_stall = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) sb.check_result(status, result_value, last);
			if (hold_go) begin
				hold_go = 0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else
				out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
		end
	end

	task automatic send(logic [3:0] op, logic [7:0] val);
		in_valid <= 1;
		opcode <= op;
		value <= val;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, val);
		sent++;
		if (!quiet && $urandom_range(99) < 32) begin
			in_valid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic keyword_build();
		int n;
		send(OP_START, 8'($urandom_range(255)));
		n = $urandom_range(15, 9);
		for (int i = 0; i < n; i++)
			if ($urandom_range(9) < 8)
				send(OP_COLKEY, 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25)));
			else
				send(OP_COLKEY, 8'($urandom_range(255)));
		n = $urandom_range(10);
		for (int i = 0; i < n; i++)
			send(OP_ALPHAKEY, 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25)));
		send(OP_FIN_KEY, 8'($urandom_range(255)));
	endtask

	task automatic direct_build();
		int perm[$];
		int bad;
		perm = {};
		for (int i = 0; i < 26; i++) perm.push_back(i);
		perm.shuffle();
		bad = ($urandom_range(9) == 0) ? int'($urandom_range(25)) : -1;
		send(OP_START, 8'd0);
		for (int i = 0; i < 26; i++)
			send(OP_ALPHA, (i == bad) ? 8'($urandom_range(255)) : 8'(perm[i]));
		if ($urandom_range(14) == 0) send(OP_ALPHA, 8'($urandom_range(25)));
		perm = {};
		for (int i = 0; i < 10; i++) perm.push_back(i);
		perm.shuffle();
		bad = ($urandom_range(9) == 0) ? int'($urandom_range(9)) : -1;
		for (int i = 0; i < 10; i++)
			send(OP_DIGIT, (i == bad) ? 8'($urandom_range(255)) : 8'(perm[i]));
		if ($urandom_range(14) == 0) send(OP_DIGIT, 8'($urandom_range(9)));
		send(OP_FIN_DIR, 8'd0);
	endtask

	task automatic use_grid(int n);
		for (int i = 0; i < n; i++)
			case ($urandom_range(9))
				0: send(4'($urandom_range(15)), 8'($urandom_range(255)));
				1, 2, 3: send(OP_QUERY, ($urandom_range(4) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(9)));
				default: send(OP_ENC, ($urandom_range(4) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(31)));
			endcase
	endtask

	initial begin
		string kw;
		sb = new();
		arst_n = 0;
		in_valid = 0;
		opcode = 0;
		value = 0;
		quiet = 0;
		hold_go = 0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// before any grid, unknown opcodes, short keyword
		send(OP_ENC, 8'd0);
		send(OP_QUERY, 8'd3);
		send(4'd9, 8'hFF);
		send(4'd15, 8'h00);
		send(OP_START, 8'd0);
		send(OP_COLKEY, "z");
		send(OP_COLKEY, "Z");
		send(OP_COLKEY, 8'hFF);
		send(OP_COLKEY, "a");
		send(OP_FIN_KEY, 8'd0);
		send(OP_FIN_DIR, 8'd0);
		// full keyword build with overflow, then extremes
		kw = "TRIDIGITALXYZ";
		foreach (kw[i]) send(OP_COLKEY, kw[i]);
		send(OP_ALPHAKEY, "q");
		send(OP_ALPHAKEY, "Q");
		send(OP_ALPHAKEY, 8'h7F);
		send(OP_FIN_KEY, 8'd0);
		send(OP_ENC, 8'd25);
		send(OP_ENC, 8'd26);
		send(OP_ENC, 8'd255);
		for (int d = 0; d < 16; d++) send(OP_QUERY, 8'(d));

		// backpressure: result side holds off while items are still offered
		hold_go = 1;
		use_grid(40);
		drain();

		while (sent < 240) begin
			quiet = (sent > 140 && sent < 200);
			case ($urandom_range(5))
				0: keyword_build();
				1: direct_build();
				2: begin
					// mixed entry kinds in one build
					send(OP_START, 8'd0);
					repeat ($urandom_range(12)) send($urandom_range(2) ? OP_DIGIT : OP_COLKEY,
						8'($urandom_range(9) + ($urandom_range(1) ? "A" : 0)));
					repeat ($urandom_range(6)) send(OP_ALPHA, 8'($urandom_range(30)));
					send($urandom_range(1) ? OP_FIN_DIR : OP_FIN_KEY, 8'd0);
				end
				default: use_grid($urandom_range(20, 5));
			endcase
			if ($urandom_range(7) == 0) drain();
		end
		quiet = 0;
		drain();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("tridigital_cipher_engine_core_tb: clean");
		else
			$display("tridigital_cipher_engine_core_tb: errors");
		$finish;
	end
endmodule

[sim.f]
rtl/tdc_pkg.sv
rtl/tridigital_cipher_engine_core.sv
dv/tridigital_cipher_engine_core_tb.sv
